[hdl/mrbr_pkg.sv]
// ----------------------------------------------------------------------------
// mrbr_pkg
// Shared types and constants of the broadcast ring.
// ----------------------------------------------------------------------------
package mrbr_pkg;

    // Fixed widths of the request and response words.
    localparam int REQ_TYPE_W  = 2;
    localparam int READER_ID_W = 3;
    localparam int WORD_W      = 64;

    // Request codes carried in req_type.
    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2
    } req_kind_t;

    // Update command from the sequencer to the reader state.
    typedef struct packed {
        logic      update;
        logic      rid_ok;
        req_kind_t kind;
    } rdr_cmd_t;

endpackage

[hdl/mrbr_req_if.sv]
// ----------------------------------------------------------------------------
// mrbr_req_if
// Request channel: valid/ready handshake with the request word.
// ----------------------------------------------------------------------------
interface mrbr_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [mrbr_pkg::REQ_TYPE_W-1:0]       req_type;
    logic [mrbr_pkg::READER_ID_W-1:0]      reader_id;
    logic [mrbr_pkg::WORD_W-1:0]           record_word;

    modport source (output valid, output req_type, output reader_id,
                    output record_word, input ready);
    modport sink   (input valid, input req_type, input reader_id,
                    input record_word, output ready);
endinterface

[hdl/mrbr_rsp_if.sv]
// ----------------------------------------------------------------------------
// mrbr_rsp_if
// Response channel: valid/ready handshake with the result word.
// ----------------------------------------------------------------------------
interface mrbr_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          record_valid;
    logic [mrbr_pkg::WORD_W-1:0]   record_out;
    logic                          reader_overrun;

    modport source (output valid, output record_valid, output record_out,
                    output reader_overrun, input ready);
    modport sink   (input valid, input record_valid, input record_out,
                    input reader_overrun, output ready);
endinterface

[hdl/mrbr_store.sv]
// ----------------------------------------------------------------------------
// mrbr_store
// Record memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mrbr_store #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/mrbr_readers.sv]
// ----------------------------------------------------------------------------
// mrbr_readers
// Per-reader read pointers, registrations and sticky overrun flags.
// ----------------------------------------------------------------------------
module mrbr_readers #(
    parameter int NUM_READERS = 8,
    parameter int RING_DEPTH  = 256
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  mrbr_pkg::rdr_cmd_t                                     cmd,
    input  logic [((NUM_READERS > 1) ? $clog2(NUM_READERS) : 1)-1:0] rid,
    input  logic [$clog2(RING_DEPTH)-1:0]                          wp,
    input  logic [$clog2(RING_DEPTH)-1:0]                          wp_next,
    output logic [$clog2(RING_DEPTH)-1:0]                          sel_ptr,
    output logic                                                   sel_flag
);

    localparam int PTR_W = $clog2(RING_DEPTH);

    logic [PTR_W-1:0] ptr_reg  [NUM_READERS];
    logic             flag_reg [NUM_READERS];
    logic             regd_reg [NUM_READERS];

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        ring_next = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Out-of-range ids are masked by rid_ok before anything is used.
    assign sel_ptr  = cmd.rid_ok ? ptr_reg[rid]  : '0;
    assign sel_flag = cmd.rid_ok ? flag_reg[rid] : 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_READERS; r++)
            begin
                ptr_reg[r]  <= '0;
                flag_reg[r] <= 1'b0;
                regd_reg[r] <= 1'b0;
            end
        end
        else if (cmd.update)
        begin
            case (cmd.kind)
                mrbr_pkg::REQ_WRITE:
                begin
                    // Every registered reader caught by the writer drops its oldest record.
                    for (int r = 0; r < NUM_READERS; r++)
                    begin
                        if (regd_reg[r] && (ptr_reg[r] == wp_next))
                        begin
                            flag_reg[r] <= 1'b1;
                            ptr_reg[r]  <= ring_next(ptr_reg[r]);
                        end
                    end
                end
                mrbr_pkg::REQ_READ:
                begin
                    if (cmd.rid_ok)
                    begin
                        regd_reg[rid] <= 1'b1;
                        if (ptr_reg[rid] != wp)
                        begin
                            ptr_reg[rid] <= ring_next(ptr_reg[rid]);
                        end
                    end
                end
                mrbr_pkg::REQ_CLEAR:
                begin
                    for (int r = 0; r < NUM_READERS; r++)
                    begin
                        ptr_reg[r]  <= '0;
                        flag_reg[r] <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

[hdl/multi_reader_broadcast_ring.sv]
// ----------------------------------------------------------------------------
// multi_reader_broadcast_ring
// One writer, many readers sharing a ring of records; oldest is overwritten.
// ----------------------------------------------------------------------------
// Usage: requests enter on the req channel and every request, whatever its
// kind, yields exactly one response word on the rsp channel. A write stores
// record_word at the write pointer; a reader that the writer catches loses
// its oldest record and gets a sticky overrun flag. A read registers the
// reader and returns its next record when one waits, along with the flag.
// A clear zeroes all pointers and flags and keeps the registrations.
// A request is accepted in the idle state and completes in the execute
// state, where its response word is registered; no new request is taken
// before it completes. The record memory's read data is registered at
// acceptance, and the pointers are updated when the request completes.
// Stall: while the response register holds an untaken word, the block still
// accepts the next request, then waits with its read data held until the
// response register frees up. Reset clears the pointers, registrations and
// flags at once; the record memory itself is not cleared.
// ----------------------------------------------------------------------------
module multi_reader_broadcast_ring #(
    parameter int NUM_READERS  = 8,
    parameter int RING_DEPTH   = 256,
    parameter int RECORD_WIDTH = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    mrbr_req_if.sink     req,
    mrbr_rsp_if.source   rsp
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int RID_W = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                     state_reg;
    mrbr_pkg::req_kind_t        kind_reg;
    logic [RID_W-1:0]           rid_reg;
    logic                       rid_ok_reg;
    logic [PTR_W-1:0]           wp_reg;
    logic                       out_valid_reg;
    logic                       out_rec_valid_reg;
    logic [mrbr_pkg::WORD_W-1:0] out_record_reg;
    logic                       out_overrun_reg;

    mrbr_pkg::req_kind_t        in_kind;
    logic                       in_rid_ok;
    logic [RID_W-1:0]           in_rid;
    logic                       accept;
    logic                       done;
    logic [PTR_W-1:0]           wp_next;
    mrbr_pkg::rdr_cmd_t         rdr_cmd;
    logic [RID_W-1:0]           rdr_rid;
    logic [PTR_W-1:0]           sel_ptr;
    logic                       sel_flag;
    logic [RECORD_WIDTH-1:0]    rd_data;
    logic                       has_record;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        ring_next = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign in_kind   = mrbr_pkg::req_kind_t'(req.req_type);
    assign in_rid_ok = (32'(req.reader_id) < NUM_READERS);
    assign in_rid    = RID_W'(req.reader_id);

    // One request in flight; the response register decouples the two sides.
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign done      = (state_reg == S_EXEC) && (!out_valid_reg || rsp.ready);
    assign wp_next   = ring_next(wp_reg);

    // The reader state is looked up with the live id at acceptance and with
    // the held id while the request completes; the pointers do not move between.
    assign rdr_rid         = (state_reg == S_IDLE) ? in_rid : rid_reg;
    assign rdr_cmd.update  = done;
    assign rdr_cmd.rid_ok  = (state_reg == S_IDLE) ? in_rid_ok : rid_ok_reg;
    assign rdr_cmd.kind    = kind_reg;

    mrbr_readers #(
        .NUM_READERS (NUM_READERS),
        .RING_DEPTH  (RING_DEPTH)
    ) u_readers (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (rdr_cmd),
        .rid      (rdr_rid),
        .wp       (wp_reg),
        .wp_next  (wp_next),
        .sel_ptr  (sel_ptr),
        .sel_flag (sel_flag)
    );

    // Writes go into the memory at acceptance; reads fetch the record at the
    // reader's pointer so it is ready in the completion cycle.
    mrbr_store #(
        .DEPTH (RING_DEPTH),
        .WIDTH (RECORD_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (accept && (in_kind == mrbr_pkg::REQ_WRITE)),
        .wr_addr (wp_reg),
        .wr_data (req.record_word[RECORD_WIDTH-1:0]),
        .rd_en   (accept && (in_kind == mrbr_pkg::REQ_READ) && in_rid_ok),
        .rd_addr (sel_ptr),
        .rd_data (rd_data)
    );

    assign has_record = rid_ok_reg && (sel_ptr != wp_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            kind_reg          <= mrbr_pkg::REQ_WRITE;
            rid_reg           <= '0;
            rid_ok_reg        <= 1'b0;
            wp_reg            <= '0;
            out_valid_reg     <= 1'b0;
            out_rec_valid_reg <= 1'b0;
            out_record_reg    <= '0;
            out_overrun_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg   <= in_kind;
                        rid_reg    <= in_rid;
                        rid_ok_reg <= in_rid_ok;
                        state_reg  <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (done)
                    begin
                        out_valid_reg     <= 1'b1;
                        out_rec_valid_reg <= 1'b0;
                        out_record_reg    <= '0;
                        out_overrun_reg   <= 1'b0;
                        case (kind_reg)
                            mrbr_pkg::REQ_WRITE:
                            begin
                                wp_reg <= wp_next;
                            end
                            mrbr_pkg::REQ_READ:
                            begin
                                out_overrun_reg <= sel_flag;
                                if (has_record)
                                begin
                                    out_rec_valid_reg <= 1'b1;
                                    out_record_reg    <= mrbr_pkg::WORD_W'(rd_data);
                                end
                            end
                            mrbr_pkg::REQ_CLEAR:
                            begin
                                wp_reg <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.record_valid   = out_rec_valid_reg;
    assign rsp.record_out     = out_record_reg;
    assign rsp.reader_overrun = out_overrun_reg;

`ifndef SYNTHESIS
    // An accepted request always moves the sequencer into its completion cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == S_EXEC))
        else $error("accepted request did not start completion");

    // A request cannot complete while an untaken response occupies the register.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EXEC) && out_valid_reg && !rsp.ready) |=> (state_reg == S_EXEC))
        else $error("request completed over a stalled response");

    // The write pointer stays inside the ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        (32'(wp_reg) < RING_DEPTH))
        else $error("write pointer outside the ring");

    // A response word that returns no record carries an all-zero record.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.record_valid) |-> (rsp.record_out == '0))
        else $error("record data present without a returned record");
`endif

endmodule

[tb/sv/multi_reader_broadcast_ring_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_reader_broadcast_ring_test
// Self-checking bench that drives requests into the broadcast ring and checks
// every response word against a behavioral copy of the ring's pointers.
// ----------------------------------------------------------------------------
module multi_reader_broadcast_ring_test;

    localparam int NUM_READERS  = 8;
    localparam int RING_DEPTH   = 256;
    localparam int RECORD_WIDTH = 64;

    localparam int REQ_TYPE_W  = mrbr_pkg::REQ_TYPE_W;
    localparam int READER_ID_W = mrbr_pkg::READER_ID_W;
    localparam int WORD_W      = mrbr_pkg::WORD_W;

    // Request code that the block must ignore; it is not part of req_kind_t.
    localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;

    // Run limits. The cycle limit leaves a wide margin over the length of the
    // run, even with the slowest idle profile.
    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int ITEMS_PER_PASS = 360;
    localparam int MAX_SEND_GAP   = 16;

    // One response word as the block presents it.
    typedef struct packed {
        logic              record_valid;
        logic [WORD_W-1:0] record_out;
        logic              reader_overrun;
    } ring_response_t;

    // Traffic mixes for the random part. Each mix holds for ten to fifty
    // words so that the ring drifts toward full or toward empty.
    typedef enum int {MIX_WRITES, MIX_READS, MIX_EVEN} traffic_mix_t;

    // ------------------------------------------------------------------------
    // Scoreboard. It keeps its own copy of the ring state, works out the
    // response for every accepted request and queues it; each response that
    // the block hands over is compared with the oldest queued entry.
    // ------------------------------------------------------------------------
    class ring_scoreboard;
        ring_response_t    awaited_responses[$];
        logic [WORD_W-1:0] ring_mem[RING_DEPTH];
        int                write_ptr;
        int                read_ptr[NUM_READERS];
        bit                registered[NUM_READERS];
        bit                overrun[NUM_READERS];
        int                errors;
        int                writes_seen;
        int                records_read;
        int                empty_reads;
        int                overrun_reads;
        int                clears_seen;
        int                unused_seen;

        function new();
            write_ptr = 0;
            for (int r = 0; r < NUM_READERS; r++)
            begin
                read_ptr[r]   = 0;
                registered[r] = 1'b0;
                overrun[r]    = 1'b0;
            end
            errors        = 0;
            writes_seen   = 0;
            records_read  = 0;
            empty_reads   = 0;
            overrun_reads = 0;
            clears_seen   = 0;
            unused_seen   = 0;
        endfunction

        function int pending();
            return awaited_responses.size();
        endfunction

        // Applies one accepted request to the ring copy and queues the
        // response word that it must produce.
        function void note_request(logic [REQ_TYPE_W-1:0] kind,
                                   logic [READER_ID_W-1:0] rid,
                                   logic [WORD_W-1:0] word);
            ring_response_t resp;
            resp = '0;
            case (kind)
                mrbr_pkg::REQ_WRITE:
                begin
                    ring_mem[write_ptr] = word;
                    write_ptr = (write_ptr + 1) % RING_DEPTH;
                    // Any registered reader that the writer has caught loses
                    // its oldest record.
                    for (int r = 0; r < NUM_READERS; r++)
                    begin
                        if (registered[r] && read_ptr[r] == write_ptr)
                        begin
                            overrun[r]  = 1'b1;
                            read_ptr[r] = (read_ptr[r] + 1) % RING_DEPTH;
                        end
                    end
                    writes_seen++;
                end
                mrbr_pkg::REQ_READ:
                begin
                    if (rid < NUM_READERS)
                    begin
                        registered[rid] = 1'b1;
                        if (read_ptr[rid] != write_ptr)
                        begin
                            resp.record_valid = 1'b1;
                            resp.record_out   = ring_mem[read_ptr[rid]];
                            read_ptr[rid]     = (read_ptr[rid] + 1) % RING_DEPTH;
                            records_read++;
                        end
                        else
                        begin
                            empty_reads++;
                        end
                        resp.reader_overrun = overrun[rid];
                        if (overrun[rid])
                            overrun_reads++;
                    end
                end
                mrbr_pkg::REQ_CLEAR:
                begin
                    // Registrations survive a clear.
                    write_ptr = 0;
                    for (int r = 0; r < NUM_READERS; r++)
                    begin
                        read_ptr[r] = 0;
                        overrun[r]  = 1'b0;
                    end
                    clears_seen++;
                end
                default:
                begin
                    unused_seen++;
                end
            endcase
            awaited_responses.push_back(resp);
        endfunction

        // Compares one accepted response word with the oldest expectation.
        function void check_response(ring_response_t actual);
            ring_response_t want;
            if (awaited_responses.size() == 0)
            begin
                $display("%0t: response with none awaited: valid=%0b out=%h ovr=%0b",
                         $time, actual.record_valid, actual.record_out,
                         actual.reader_overrun);
                errors++;
                return;
            end
            want = awaited_responses.pop_front();
            if (actual.record_valid !== want.record_valid)
            begin
                $display("%0t: record_valid expected %0b actual %0b",
                         $time, want.record_valid, actual.record_valid);
                errors++;
            end
            if (actual.record_out !== want.record_out)
            begin
                $display("%0t: record_out expected %h actual %h",
                         $time, want.record_out, actual.record_out);
                errors++;
            end
            if (actual.reader_overrun !== want.reader_overrun)
            begin
                $display("%0t: reader_overrun expected %0b actual %0b",
                         $time, want.reader_overrun, actual.reader_overrun);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_idle_pct;

    ring_scoreboard board;

    mrbr_req_if req_ch ();
    mrbr_rsp_if rsp_ch ();

    multi_reader_broadcast_ring #(
        .NUM_READERS  (NUM_READERS),
        .RING_DEPTH   (RING_DEPTH),
        .RECORD_WIDTH (RECORD_WIDTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Watchdog: a hung handshake or a lost response ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver side. Ready is redrawn at every falling edge from the current
    // idle percentage; a word counts as taken at the rising edge where valid
    // and ready are both high.
    always @(negedge clk)
    begin
        rsp_ch.ready = rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            board.check_response({rsp_ch.record_valid, rsp_ch.record_out,
                                  rsp_ch.reader_overrun});
    end

    // Presents one request word, after a random number of idle cycles, and
    // holds it until the block takes it. Fields only change at falling
    // edges, and valid gets one assignment per edge.
    task automatic send_word(logic [REQ_TYPE_W-1:0] kind,
                             logic [READER_ID_W-1:0] rid,
                             logic [WORD_W-1:0] word);
        int gap;
        gap = 0;
        while (gap < MAX_SEND_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid       = 1'b1;
        req_ch.req_type    = kind;
        req_ch.reader_id   = rid;
        req_ch.record_word = word;
        do
            @(posedge clk);
        while (!req_ch.ready);
        board.note_request(kind, rid, word);
    endtask

    // Drops valid and holds off until every queued response has come back.
    task automatic drain_responses();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [WORD_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Readers are polled unevenly: the low ones are picked most often, the
    // high ones fall behind and are the first to lose records.
    function automatic logic [READER_ID_W-1:0] pick_reader();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return READER_ID_W'($urandom_range(3));
        if (roll < 95)
            return READER_ID_W'(4 + $urandom_range(1));
        return READER_ID_W'(6 + $urandom_range(1));
    endfunction

    // Short directed opening: empty reads, the ignored code with every bit
    // set, extreme record values, every reader, and a clear that must keep
    // the registrations while zeroing pointers and flags.
    task automatic run_directed();
        send_word(mrbr_pkg::REQ_READ, 3'd0, '0);
        send_word(REQ_UNUSED, '1, '1);
        send_word(mrbr_pkg::REQ_WRITE, 3'd0, '0);
        send_word(mrbr_pkg::REQ_WRITE, 3'd0, '1);
        send_word(mrbr_pkg::REQ_WRITE, 3'd5, {WORD_W/2{2'b10}});
        send_word(mrbr_pkg::REQ_WRITE, 3'd2, {WORD_W/2{2'b01}});
        send_word(mrbr_pkg::REQ_READ, 3'd0, '1);
        send_word(mrbr_pkg::REQ_READ, 3'd0, '0);
        send_word(mrbr_pkg::REQ_READ, 3'd7, '0);
        send_word(mrbr_pkg::REQ_READ, 3'd0, '0);
        send_word(mrbr_pkg::REQ_READ, 3'd0, '0);
        send_word(mrbr_pkg::REQ_READ, 3'd0, '0);
        for (int r = 1; r < NUM_READERS; r++)
            send_word(mrbr_pkg::REQ_READ, READER_ID_W'(r), random_word());
        send_word(mrbr_pkg::REQ_CLEAR, 3'd4, '1);
        send_word(mrbr_pkg::REQ_READ, 3'd7, '0);
        send_word(mrbr_pkg::REQ_WRITE, 3'd0, 64'h8000_0000_0000_0001);
        send_word(mrbr_pkg::REQ_READ, 3'd7, '0);
    endtask

    // Random traffic. The mix changes every ten to fifty words; clears and the
    // ignored code are rare so that pointers get to drift a long way. With
    // a burst, one long run of writes laps every registered reader, which
    // forces overruns and pointer wrap.
    task automatic run_random(int item_count, bit with_burst);
        traffic_mix_t mix;
        int           mix_left;
        int           burst_at;
        int           burst_len;
        int           sent;
        int           roll;
        int           write_pct;
        mix      = MIX_EVEN;
        mix_left = 0;
        sent     = 0;
        burst_at = with_burst ? $urandom_range(item_count / 4, item_count / 2) : -1;
        while (sent < item_count)
        begin
            if (sent == burst_at)
            begin
                burst_len = $urandom_range(RING_DEPTH + 4, RING_DEPTH + 44);
                repeat (burst_len)
                    send_word(mrbr_pkg::REQ_WRITE, pick_reader(), random_word());
                sent += burst_len;
                continue;
            end
            if (mix_left == 0)
            begin
                mix      = traffic_mix_t'($urandom_range(2));
                mix_left = $urandom_range(10, 50);
            end
            mix_left--;
            case (mix)
                MIX_WRITES: write_pct = 75;
                MIX_READS:  write_pct = 20;
                default:    write_pct = 50;
            endcase
            roll = $urandom_range(999);
            if (roll < 5)
                send_word(mrbr_pkg::REQ_CLEAR, pick_reader(), random_word());
            else if (roll < 15)
                send_word(REQ_UNUSED, READER_ID_W'($urandom_range(7)), random_word());
            else if ($urandom_range(99) < write_pct)
                send_word(mrbr_pkg::REQ_WRITE, pick_reader(), random_word());
            else
                send_word(mrbr_pkg::REQ_READ, pick_reader(), random_word());
            sent++;
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = mrbr_pkg::REQ_WRITE;
        req_ch.reader_id   = '0;
        req_ch.record_word = '0;
        send_idle_pct      = 22;
        recv_idle_pct      = 69;
        board              = new();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Sender mostly busy, receiver slow: responses back up and the block
        // has to hold accepted requests while its output register is full.
        run_directed();
        drain_responses();
        run_random(ITEMS_PER_PASS, 1'b0);
        drain_responses();

        // Sender slow, receiver mostly ready; this pass carries the long
        // write burst.
        send_idle_pct = 69;
        recv_idle_pct = 22;
        run_random(ITEMS_PER_PASS, 1'b1);
        drain_responses();

        // Back to back on both sides at the full rate of the block.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(ITEMS_PER_PASS, 1'b0);
        drain_responses();

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d writes, %0d reads with a record, %0d empty reads,",
                 board.writes_seen, board.records_read, board.empty_reads);
        $display("%0d reads flagging overrun, %0d clears, %0d ignored requests.",
                 board.overrun_reads, board.clears_seen, board.unused_seen);
        if (board.errors == 0 && board.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
